// ----- hdl/linear_congruence_solver_macros.svh -----
// Assertion macros used by the checker file of the linear congruence solver.
`ifndef LINEAR_CONGRUENCE_SOLVER_MACROS_SVH
`define LINEAR_CONGRUENCE_SOLVER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and held off during reset.
`define LCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("linear_congruence_solver check failed");

// Next-cycle implication, sampled on the rising clock edge and held off during reset.
`define LCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("linear_congruence_solver check failed");

`endif

// ----- hdl/lcs_pkg.sv -----
`default_nettype none

package lcs_pkg;

    // Handshake state that the divider reports back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ----- hdl/lcs_divider.sv -----
`default_nettype none

module lcs_divider #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [OPERAND_WIDTH-1:0]   dividend,
    input  wire logic [OPERAND_WIDTH-2:0]   divisor,
    input  wire logic signed [OPERAND_WIDTH:0] mult,
    output logic      [OPERAND_WIDTH-1:0]   quotient,
    output logic      [OPERAND_WIDTH-2:0]   remainder,
    output logic signed [OPERAND_WIDTH:0]   product,
    output lcs_pkg::div_status_t            status
);
    import lcs_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int N  = OPERAND_WIDTH - 1;
    localparam int CW = $clog2(OPERAND_WIDTH + 1);

    logic        [W-1:0]  quo_reg;
    logic        [N-1:0]  rem_reg;
    logic        [N-1:0]  dsr_reg;
    logic signed [W:0]    mult_reg;
    logic signed [W:0]    acc_reg;
    logic        [CW-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [N:0] trial;
    logic [N:0] diff;
    logic       qbit;

    // One restoring division step per cycle; the quotient bit also drives a
    // Horner accumulation of quotient times mult.
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                rem_reg <= qbit ? diff[N-1:0] : trial[N-1:0];
                quo_reg <= {quo_reg[W-2:0], qbit};
                acc_reg <= (acc_reg <<< 1) + (qbit ? mult_reg : '0);
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                mult_reg <= mult;
                acc_reg  <= '0;
                cnt_reg  <= CW'(W);
                busy_reg <= 1'b1;
            end
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ----- hdl/linear_congruence_solver.sv -----
// Channel  | Ports                                              | Direction
// request  | s_valid s_ready s_coefficient s_modulus s_right_side | in
// result   | m_valid m_ready m_solution m_divisor m_solvable      | out
//
// One request is worked on at a time; s_ready is high only while the sequencer is idle.
// Each Euclid quotient step is one division in the shared divider, two more divisions
// follow, then up to OPERAND_WIDTH - 1 modular doubling steps before m_valid.
// A zero modulus skips the divider and goes straight to the final state.
// Reset is synchronous on aresetn, active low.
// A result waiting on m_ready holds the sequencer in its final state.
`default_nettype none

module linear_congruence_solver #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [OPERAND_WIDTH-2:0]     s_coefficient,
    input  wire logic [OPERAND_WIDTH-2:0]     s_modulus,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_right_side,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [OPERAND_WIDTH-2:0]          m_solution,
    output logic [OPERAND_WIDTH-2:0]          m_divisor,
    output logic                              m_solvable
);
    import lcs_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam int N = OPERAND_WIDTH - 1;
    localparam int S = OPERAND_WIDTH + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EUC,
        ST_EUC_WAIT,
        ST_DIVG,
        ST_DIVG_WAIT,
        ST_REDUCE,
        ST_DIVQ,
        ST_DIVQ_WAIT,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Request operands. The magnitude of the right side needs the full width,
    // since the most negative value has no positive counterpart in fewer bits.
    logic        [N-1:0] b_reg;
    logic                neg_reg;
    logic        [W-1:0] mag_reg;
    logic                solv_reg;

    // Euclid remainders and Bezout coefficients. The coefficients never exceed
    // the modulus in magnitude, so S bits of two's complement hold them exactly.
    logic        [N-1:0] r0_reg;
    logic        [N-1:0] r1_reg;
    logic signed [S-1:0] s0_reg;
    logic signed [S-1:0] s1_reg;
    logic        [W-1:0] q_reg;

    // Modular multiply by doubling and adding.
    logic        [N-1:0] x_reg;
    logic        [N-1:0] y_reg;
    logic        [N-1:0] acc_reg;

    logic                m_valid_reg;
    logic        [N-1:0] m_solution_reg;
    logic        [N-1:0] m_divisor_reg;
    logic                m_solvable_reg;

    // Shared divider.
    logic                div_start;
    logic        [W-1:0] div_dividend;
    logic        [N-1:0] div_divisor;
    logic signed [S-1:0] div_mult;
    logic        [W-1:0] div_quotient;
    logic        [N-1:0] div_remainder;
    logic signed [S-1:0] div_product;
    div_status_t         div_st;

    lcs_divider #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .mult      (div_mult),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .product   (div_product),
        .status    (div_st)
    );

    // The sequencer picks the divider operands by phase: a Euclid step divides
    // r0 by r1 and forms quotient times s1, the divisibility test divides the
    // right side magnitude by the gcd, and the last division reduces that
    // quotient modulo the modulus.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_mult     = '0;
        unique case (state_reg)
            ST_EUC: begin
                div_start    = (r1_reg != '0);
                div_dividend = {1'b0, r0_reg};
                div_divisor  = r1_reg;
                div_mult     = s1_reg;
            end
            ST_DIVG: begin
                div_start    = 1'b1;
                div_dividend = mag_reg;
                div_divisor  = r0_reg;
            end
            ST_DIVQ: begin
                div_start    = 1'b1;
                div_dividend = q_reg;
                div_divisor  = b_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Right side magnitude and sign of the incoming request.
    logic [W-1:0] rs_u;
    logic [W-1:0] rs_mag;

    assign rs_u   = $unsigned(s_right_side);
    assign rs_mag = rs_u[W-1] ? (~rs_u + {{(W-1){1'b0}}, 1'b1}) : rs_u;

    // Bring the Bezout coefficient, which lies within plus or minus the
    // modulus, into the range 0 to modulus-1.
    logic [S-1:0] b_ext;
    logic [S-1:0] sv;
    logic [S-1:0] sv_red;

    assign b_ext  = {2'b00, b_reg};
    assign sv     = s0_reg[S-1] ? ($unsigned(s0_reg) + b_ext) : $unsigned(s0_reg);
    assign sv_red = (sv >= b_ext) ? (sv - b_ext) : sv;

    // One step of the modular multiply: conditional add of x, then doubling
    // of x, each folded back below the modulus by a single subtraction.
    logic [N:0] mm_sum;
    logic [N:0] mm_sum_red;
    logic [N:0] mm_dbl;
    logic [N:0] mm_dbl_red;

    assign mm_sum     = {1'b0, acc_reg} + {1'b0, x_reg};
    assign mm_sum_red = (mm_sum >= {1'b0, b_reg}) ? (mm_sum - {1'b0, b_reg}) : mm_sum;
    assign mm_dbl     = {x_reg, 1'b0};
    assign mm_dbl_red = (mm_dbl >= {1'b0, b_reg}) ? (mm_dbl - {1'b0, b_reg}) : mm_dbl;

    // A negative right side negates the product modulo the modulus.
    logic [N-1:0] final_sol;

    assign final_sol = (neg_reg && (acc_reg != '0)) ? (b_reg - acc_reg) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In the final state the load of the output register below owns
            // the valid flag, so the drain is handled here only elsewhere.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        b_reg   <= s_modulus;
                        neg_reg <= rs_u[W-1];
                        mag_reg <= rs_mag;
                        r0_reg  <= s_coefficient;
                        r1_reg  <= s_modulus;
                        s0_reg  <= S'(1);
                        s1_reg  <= '0;
                        if (s_modulus == '0) begin
                            solv_reg  <= 1'b0;
                            state_reg <= ST_DONE;
                        end else begin
                            solv_reg  <= 1'b1;
                            state_reg <= ST_EUC;
                        end
                    end
                end
                ST_EUC: begin
                    // A zero remainder ends the loop with the gcd in r0.
                    state_reg <= (r1_reg == '0) ? ST_DIVG : ST_EUC_WAIT;
                end
                ST_EUC_WAIT: begin
                    if (div_st.done) begin
                        r0_reg    <= r1_reg;
                        r1_reg    <= div_remainder;
                        s0_reg    <= s1_reg;
                        s1_reg    <= s0_reg - div_product;
                        state_reg <= ST_EUC;
                    end
                end
                ST_DIVG: begin
                    state_reg <= ST_DIVG_WAIT;
                end
                ST_DIVG_WAIT: begin
                    if (div_st.done) begin
                        q_reg <= div_quotient;
                        if (div_remainder != '0) begin
                            solv_reg  <= 1'b0;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE: begin
                    x_reg     <= sv_red[N-1:0];
                    state_reg <= ST_DIVQ;
                end
                ST_DIVQ: begin
                    state_reg <= ST_DIVQ_WAIT;
                end
                ST_DIVQ_WAIT: begin
                    if (div_st.done) begin
                        y_reg     <= div_remainder;
                        acc_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (y_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        if (y_reg[0]) begin
                            acc_reg <= mm_sum_red[N-1:0];
                        end
                        x_reg <= mm_dbl_red[N-1:0];
                        y_reg <= y_reg >> 1;
                    end
                end
                ST_DONE: begin
                    // Wait until the output register is free or being emptied.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_solvable_reg <= solv_reg;
                        m_solution_reg <= solv_reg ? final_sol : '0;
                        m_divisor_reg  <= solv_reg ? r0_reg : '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_solution = m_solution_reg;
    assign m_divisor  = m_divisor_reg;
    assign m_solvable = m_solvable_reg;

endmodule

`default_nettype wire

// ----- hdl/lcs_checker.sv -----
`default_nettype none
`include "linear_congruence_solver_macros.svh"

module lcs_checker #(
    parameter int OPERAND_WIDTH = 32
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [OPERAND_WIDTH-2:0] m_solution,
    input wire logic [OPERAND_WIDTH-2:0] m_divisor,
    input wire logic                     m_solvable
);

    // A stalled result holds its payload.
    `LCS_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_solution) && $stable(m_divisor) && $stable(m_solvable))

    // An unsolvable request reports zero solution and zero divisor.
    `LCS_ASSERT_IMP(a_unsolv_zero, aclk, aresetn, m_valid && !m_solvable, (m_solution == '0) && (m_divisor == '0))

    // A solvable request always has a nonzero gcd.
    `LCS_ASSERT_IMP(a_solv_gcd, aclk, aresetn, m_valid && m_solvable, m_divisor != '0)

    // The block is busy the cycle after it takes a request.
    `LCS_ASSERT_NXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind linear_congruence_solver lcs_checker #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
) u_lcs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_solution (m_solution),
    .m_divisor  (m_divisor),
    .m_solvable (m_solvable)
);

`default_nettype wire

// ----- tb/sv/linear_congruence_solver_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the linear congruence solver. A short table of
// hand-picked requests covers the special cases (zero modulus, zero
// coefficient, a gcd that does not divide the right side, and the field
// extremes). A long run of random requests follows. Every accepted request
// gets its answer from its table row or from an extended Euclid predictor
// kept in this file; the answers are checked in order against the result channel.
module linear_congruence_solver_tb;

    localparam int OPW = 32;

    // Random request counts. The last CALM_REQUESTS requests go
    // through with no idling on either side.
    localparam int RANDOM_REQUESTS = 1330;
    localparam int CALM_REQUESTS = 150;

    // The slowest request takes about 47 Euclid divisions plus the doubling
    // pass. The limit allows several times the slowest possible run, idling
    // included.
    localparam int CYCLE_LIMIT = 12_000_000;

    // At this many checked results the result side holds off for a stretch
    // much longer than one request takes, so the block backs up.
    localparam int HOLD_AFTER_RESULTS = 300;
    localparam int HOLD_CYCLES = 2500;

    // Cycles to wait after the last answer arrives, to catch a stray extra result.
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [OPW-2:0] solution;
        logic [OPW-2:0] divisor;
        logic           solvable;
    } answer_t;

    // One row of the directed table. When typed_in is set the answer is the
    // one typed in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [OPW-2:0] coefficient;
        logic [OPW-2:0] modulus;
        logic [OPW-1:0] right_side;
        logic           typed_in;
        answer_t        answer;
    } request_row_t;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    logic [OPW-2:0] s_coefficient;
    logic [OPW-2:0] s_modulus;
    logic [OPW-1:0] s_right_side;
    logic           m_valid;
    logic           m_ready;
    logic [OPW-2:0] m_solution;
    logic [OPW-2:0] m_divisor;
    logic           m_solvable;

    // Answers of accepted requests that have not come out yet, oldest first.
    answer_t      pending_answers[$];
    request_row_t directed_rows[$];

    int  mismatches = 0;
    int  results_checked = 0;
    int  cycle_count = 0;
    bit  calm_phase = 1'b0;
    bit  in_long_hold = 1'b0;

    linear_congruence_solver #(
        .OPERAND_WIDTH(OPW)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_coefficient(s_coefficient),
        .s_modulus    (s_modulus),
        .s_right_side (s_right_side),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_solution   (m_solution),
        .m_divisor    (m_divisor),
        .m_solvable   (m_solvable)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Finds an x from 0 to modulus-1 with coefficient * x == right_side
    // modulo the modulus. The Bezout coefficient is carried in 64-bit
    // wrapping arithmetic, so a negative value shows up with its top bit set.
    // All operands stay below 2^31, so the final product fits in 64 bits.
    function automatic answer_t solve_congruence(input logic [OPW-2:0] coefficient,
                                                 input logic [OPW-2:0] modulus,
                                                 input logic [OPW-1:0] right_side);
        answer_t        ans;
        logic           negative;
        logic [OPW-1:0] rhs_mag;
        logic [63:0]    r_prev, r_cur, s_prev, s_cur, quot, tmp;
        logic [63:0]    gcd_val, magnitude, scaled, s_reduced, prod;
        ans = '0;
        negative = right_side[OPW-1];
        rhs_mag = negative ? -right_side : right_side;
        magnitude = 64'(rhs_mag);
        if (modulus == '0) begin
            return ans;
        end
        r_prev = 64'(coefficient);
        r_cur = 64'(modulus);
        s_prev = 64'd1;
        s_cur = 64'd0;
        while (r_cur != 64'd0) begin
            quot = r_prev / r_cur;
            tmp = r_prev - quot * r_cur;
            r_prev = r_cur;
            r_cur = tmp;
            tmp = s_prev - quot * s_cur;
            s_prev = s_cur;
            s_cur = tmp;
        end
        gcd_val = r_prev;
        if (magnitude % gcd_val != 64'd0) begin
            return ans;
        end
        scaled = (magnitude / gcd_val) % 64'(modulus);
        if (s_prev[63]) begin
            tmp = (-s_prev) % 64'(modulus);
            s_reduced = (tmp == 64'd0) ? 64'd0 : 64'(modulus) - tmp;
        end else begin
            s_reduced = s_prev % 64'(modulus);
        end
        prod = (s_reduced * scaled) % 64'(modulus);
        if (negative && prod != 64'd0) begin
            prod = 64'(modulus) - prod;
        end
        ans.solution = prod[OPW-2:0];
        ans.divisor = gcd_val[OPW-2:0];
        ans.solvable = 1'b1;
        return ans;
    endfunction

    // Presents one request and returns at the edge where it is accepted.
    // Valid is only ever raised here, so it stays high across back-to-back
    // requests without a low pulse in between.
    task automatic offer_request(input logic [OPW-2:0] coefficient,
                                 input logic [OPW-2:0] modulus,
                                 input logic [OPW-1:0] right_side,
                                 input answer_t        answer);
        s_valid <= 1'b1;
        s_coefficient <= coefficient;
        s_modulus <= modulus;
        s_right_side <= right_side;
        do @(posedge aclk); while (!s_ready);
        pending_answers.insert(pending_answers.size(), answer);
    endtask

    // Random idle burst on the request side between requests; none in the
    // calm tail and none while the result side is holding off, so the block
    // always has a request waiting during the long hold.
    task automatic request_gap();
        int gap;
        if (!calm_phase && !in_long_hold && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Compares one accepted result with the oldest pending answer.
    task automatic check_result();
        answer_t want;
        if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result with no request pending: %h %h %b",
                         $realtime, m_solution, m_divisor, m_solvable);
            end
            return;
        end
        want = pending_answers.pop_front();
        results_checked++;
        if (m_solution !== want.solution || m_divisor !== want.divisor
                || m_solvable !== want.solvable) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result %0d expected solution %h divisor %h solvable %b",
                         $realtime, results_checked, want.solution, want.divisor,
                         want.solvable);
                $display("%0t: result %0d got solution %h divisor %h solvable %b",
                         $realtime, results_checked, m_solution, m_divisor,
                         m_solvable);
            end
        end
    endtask

    // Result side. Checks at every accepted edge, then picks m_ready for the
    // next cycle: short random stalls, one long hold, and no stalls in the
    // calm tail of the run.
    initial begin : result_side
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
                if (stall_left == 0) begin
                    in_long_hold = 1'b0;
                end
            end else if (!hold_done && results_checked >= HOLD_AFTER_RESULTS) begin
                hold_done = 1'b1;
                in_long_hold = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_answers.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : request_side
        int             idx;
        int             kind;
        int unsigned    factor;
        int unsigned    span;
        logic [OPW-2:0] coefficient;
        logic [OPW-2:0] modulus;
        logic [OPW-1:0] right_side;
        request_row_t   row;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_coefficient = '0;
        s_modulus = '0;
        s_right_side = '0;

        // coefficient, modulus, right side, typed-in flag, typed-in answer
        directed_rows = '{
            // A zero modulus never has a solution.
            '{31'd5,          31'd0,          32'd7,          1'b1, '{31'd0, 31'd0, 1'b0}},
            '{31'h7FFF_FFFF,  31'd0,          32'h8000_0000,  1'b1, '{31'd0, 31'd0, 1'b0}},
            '{31'd0,          31'd0,          32'd0,          1'b1, '{31'd0, 31'd0, 1'b0}},
            // Zero coefficient: the gcd is the modulus and x is zero when solvable.
            '{31'd0,          31'd7,          32'd14,         1'b1, '{31'd0, 31'd7, 1'b1}},
            '{31'd0,          31'd7,          -32'sd14,       1'b1, '{31'd0, 31'd7, 1'b1}},
            '{31'd0,          31'd7,          32'd15,         1'b1, '{31'd0, 31'd0, 1'b0}},
            // The gcd does not divide the right side.
            '{31'd4,          31'd6,          32'd3,          1'b1, '{31'd0, 31'd0, 1'b0}},
            '{31'd6,          31'd9,          32'd4,          1'b1, '{31'd0, 31'd0, 1'b0}},
            // Modulus one: everything is congruent to zero.
            '{31'd1,          31'd1,          32'd0,          1'b1, '{31'd0, 31'd1, 1'b1}},
            '{31'd12345,      31'd1,          32'h8000_0000,  1'b1, '{31'd0, 31'd1, 1'b1}},
            // Field extremes.
            '{31'h7FFF_FFFF,  31'h7FFF_FFFF,  32'd0,          1'b1,
              '{31'd0, 31'h7FFF_FFFF, 1'b1}},
            '{31'd1,          31'h7FFF_FFFF,  -32'sd1,        1'b1,
              '{31'h7FFF_FFFE, 31'd1, 1'b1}},
            '{31'd1,          31'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b1, '{31'd0, 31'd1, 1'b1}},
            '{31'h7FFF_FFFF,  31'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b0, '0},
            '{31'd1,          31'h7FFF_FFFF,  32'h8000_0000,  1'b0, '0},
            '{31'h7FFF_FFFF,  31'h7FFF_FFFE,  32'h7FFF_FFFF,  1'b0, '0},
            // Ordinary cases, a coefficient above the modulus, negative sides.
            '{31'd3,          31'd7,          32'd1,          1'b0, '0},
            '{31'd2,          31'd4,          -32'sd2,        1'b0, '0},
            '{31'd100,        31'd7,          -32'sd1,        1'b0, '0},
            '{31'd6,          31'd9,          32'd3,          1'b0, '0},
            // Consecutive Fibonacci numbers give the longest Euclid run.
            '{31'd1134903170, 31'd1836311903, 32'd12345,      1'b0, '0},
            '{31'd1836311903, 31'd1134903170, -32'sd12345,    1'b0, '0},
            // Alternating bit patterns.
            '{31'h5555_5555,  31'h2AAA_AAAA,  32'hAAAA_AAAA,  1'b0, '0},
            '{31'h2AAA_AAAA,  31'h5555_5555,  32'h5555_5555,  1'b0, '0}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_request(row.coefficient, row.modulus, row.right_side,
                          row.typed_in ? row.answer
                                       : solve_congruence(row.coefficient, row.modulus,
                                                          row.right_side));
            request_gap();
        end

        // Random requests. The largest share are full-width operands, which are nearly
        // always solvable; a good share is built around a common factor so
        // the divisibility test goes both ways; the rest covers tiny values,
        // the zero and one corner cases and operands of random magnitude.
        for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
            if (idx >= RANDOM_REQUESTS - CALM_REQUESTS) begin
                calm_phase = 1'b1;
            end
            kind = $urandom_range(0, 99);
            coefficient = (OPW-1)'($urandom);
            modulus = (OPW-1)'($urandom);
            right_side = $urandom;
            if (kind < 35) begin
                // Full-width operands as drawn.
            end else if (kind < 60) begin
                factor = $urandom_range(2, 4096);
                span = 32'h7FFF_FFFF / factor;
                coefficient = (OPW-1)'(factor * $urandom_range(0, span));
                modulus = (OPW-1)'(factor * $urandom_range(1, span));
                if ($urandom_range(0, 1) == 0) begin
                    right_side = factor * $urandom_range(0, span);
                    if ($urandom_range(0, 1) == 0) begin
                        right_side = -right_side;
                    end
                end
            end else if (kind < 75) begin
                coefficient = (OPW-1)'($urandom_range(0, 15));
                modulus = (OPW-1)'($urandom_range(0, 15));
                right_side = $urandom_range(0, 31) - 16;
            end else if (kind < 85) begin
                case ($urandom_range(0, 3))
                    0: modulus = '0;
                    1: coefficient = '0;
                    2: modulus = (OPW-1)'(1);
                    default: begin
                        coefficient = '0;
                        modulus = (OPW-1)'($urandom_range(1, 64));
                        right_side = modulus * ($urandom_range(0, 1000) - 500);
                    end
                endcase
            end else begin
                coefficient = coefficient >> $urandom_range(0, OPW - 2);
                modulus = modulus >> $urandom_range(0, OPW - 2);
                right_side = $signed(right_side) >>> $urandom_range(0, OPW - 1);
            end
            offer_request(coefficient, modulus, right_side,
                          solve_congruence(coefficient, modulus, right_side));
            request_gap();
        end
        s_valid <= 1'b0;

        // Let every answer come out, then watch a little longer for extras.
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
